>>> rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ANY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rbd_pkg.sv
// Shared types, constants and register codes of the RGB box downscaler.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_SUM_BITS   = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MAX_SCALE_LOG2 = 4;
  localparam int ROW_BITS       = 12;
  localparam int SIZE_BITS      = 13;
  localparam int ADDR_BITS      = 5;
  localparam int RED_SHIFT      = 16;
  localparam int GREEN_SHIFT    = 8;
  localparam int CHAN_BITS      = 8;
  localparam int NUM_CHAN       = 3;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 2;

  // Register indexes, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_SCALE       = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_RED_MASK    = 3'd3,
    REG_GREEN_MASK  = 3'd4,
    REG_BLUE_MASK   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]           scale_log2;
    logic [SIZE_BITS-1:0] frame_width;
    logic [SIZE_BITS-1:0] frame_height;
    logic [31:0]          red_sel;
    logic [31:0]          green_sel;
    logic [31:0]          blue_sel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_log2:   3'd0,
    frame_width:  13'd1024,
    frame_height: 13'd768,
    red_sel:      32'h00FF_0000,
    green_sel:    32'h0000_FF00,
    blue_sel:     32'h0000_00FF
  };

  // Per-beat control from the front to the back
  typedef struct packed {
    logic       y_zero;      // first row of a block: column sum starts fresh
    logic       is_out;      // last row of a block: emit the average
    logic       frame_done;  // block closes the frame
    logic [2:0] shift;       // effective scale_log2
  } ctl_t;

endpackage

>>> rtl/rgb_box_downscaler.sv
// Top level of the RGB box downscaler: registers, front, middle queue, back.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------------
//  config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//  pixel in  | push, full                     | raw_pixel
//  result    | pop, empty                     | red_avg, green_avg, blue_avg, frame_done
//
// Sustained rate is one pixel per clock while full is low; the column sum memory does
// one read and one write per clock, with the write forwarded to a same-address read.
// A pixel that closes a block goes through the middle queue, the back stage register and
// the result queue before it shows on the result ports. After reset, full stays high
// while the column sum memory is swept to zero; register writes are taken meanwhile.
// A stalled result side fills the result queue, back stage and middle queue, then full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_box_downscaler #(
  parameter int MAX_WIDTH        = rbd_pkg::DEF_MAX_WIDTH,
  parameter int CHANNEL_SUM_BITS = rbd_pkg::DEF_SUM_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   raw_pixel,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0]                    red_avg,
  output logic [7:0]                    green_avg,
  output logic [7:0]                    blue_avg,
  output logic                          frame_done
);
  import rbd_pkg::*;

  localparam int AW = $clog2((MAX_WIDTH + 1) / 2);
  localparam int SB = CHANNEL_SUM_BITS;
  localparam int QW = AW + NUM_CHAN * SB + $bits(ctl_t);

  cfg_t                        cfg;
  reg_idx_t                    reg_idx;
  logic                        cfg_wr;
  logic                        mid_push;
  logic                        mid_full;
  logic                        mid_pop;
  logic                        mid_empty;
  logic [QW-1:0]               mid_wdata;
  logic [QW-1:0]               mid_rdata;
  logic [AW-1:0]               f_addr;
  logic [NUM_CHAN-1:0][SB-1:0] f_sum;
  ctl_t                        f_ctl;
  logic [AW-1:0]               b_addr;
  logic [NUM_CHAN-1:0][SB-1:0] b_sum;
  ctl_t                        b_ctl;
  logic                        busy;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCALE:      cfg.scale_log2   <= pwdata[2:0];
        REG_WIDTH:      cfg.frame_width  <= pwdata[SIZE_BITS-1:0];
        REG_HEIGHT:     cfg.frame_height <= pwdata[SIZE_BITS-1:0];
        REG_RED_MASK:   cfg.red_sel      <= pwdata;
        REG_GREEN_MASK: cfg.green_sel    <= pwdata;
        REG_BLUE_MASK:  cfg.blue_sel     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE:      prdata = 32'(cfg.scale_log2);
      REG_WIDTH:      prdata = 32'(cfg.frame_width);
      REG_HEIGHT:     prdata = 32'(cfg.frame_height);
      REG_RED_MASK:   prdata = cfg.red_sel;
      REG_GREEN_MASK: prdata = cfg.green_sel;
      REG_BLUE_MASK:  prdata = cfg.blue_sel;
      default:        prdata = '0;
    endcase
  end

  // input side stalls on a full middle queue or the clearing sweep
  assign full = mid_full || busy;

  rbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .SUM_BITS  (SB)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .raw_pixel (raw_pixel),
    .item_push (mid_push),
    .item_addr (f_addr),
    .item_sum  (f_sum),
    .item_ctl  (f_ctl)
  );

  // middle queue between front and back
  assign mid_wdata = {f_addr, f_sum, f_ctl};

  rbd_queue #(
    .W     (QW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign {b_addr, b_sum, b_ctl} = mid_rdata;

  rbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .SUM_BITS  (SB)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (mid_empty),
    .q_pop      (mid_pop),
    .q_addr     (b_addr),
    .q_sum      (b_sum),
    .q_ctl      (b_ctl),
    .busy       (busy),
    .pop        (pop),
    .empty      (empty),
    .red_avg    (red_avg),
    .green_avg  (green_avg),
    .blue_avg   (blue_avg),
    .frame_done (frame_done)
  );

  // checks
  `ASSERT_NEXT_ANY(a_full_after_reset, rst, full, "input open right after reset")
  `ASSERT_IMPL(a_no_beats_while_clearing, busy, mid_empty, "beat queued during clear sweep")
  `ASSERT_IMPL(a_mid_no_overflow, mid_push, !mid_full, "front pushed into a full queue")

endmodule

>>> rtl/rbd_queue.sv
// Small register-based FIFO used between the stages and on the result side.
`timescale 1ns / 1ps
module rbd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slots [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CNTW-1:0] cnt;
  logic            wr;
  logic            rd;

  assign empty = (cnt == '0);
  assign full  = (cnt == CNTW'(DEPTH));
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = slots[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wdata;
    end
  end

endmodule

>>> rtl/rbd_front.sv
// Front end: splits pixels into channels, tracks position, sums along the block row.
`timescale 1ns / 1ps
module rbd_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int SUM_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rbd_pkg::cfg_t                          cfg,
  input  logic                                   push,
  input  logic                                   full,
  input  logic [31:0]                            raw_pixel,
  output logic                                   item_push,
  output logic [$clog2((MAX_WIDTH+1)/2)-1:0]     item_addr,
  output logic [rbd_pkg::NUM_CHAN-1:0][SUM_BITS-1:0] item_sum,
  output rbd_pkg::ctl_t                          item_ctl
);
  import rbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int AW = $clog2((MAX_WIDTH + 1) / 2);

  logic [CW-1:0]                      col;
  logic [CW-1:0]                      col_next;
  logic [ROW_BITS-1:0]                row;
  logic [ROW_BITS-1:0]                row_next;
  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  rbs;
  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  rbs_next;
  logic [NUM_CHAN-1:0][CHAN_BITS-1:0] chan;
  logic [31:0]                        masked_r;
  logic [31:0]                        masked_g;
  logic [31:0]                        masked_b;
  logic [2:0]                         s_eff;
  logic [3:0]                         m;
  logic [3:0]                         x;
  logic [3:0]                         y;
  logic [15:0]                        fw16;
  logic [WW-1:0]                      w_eff;
  logic [SIZE_BITS-1:0]               h_eff;
  logic                               last_col;
  logic                               last_row;
  logic                               accept;

  assign accept = push && !full;

  // channel extraction
  assign masked_r = raw_pixel & cfg.red_sel;
  assign masked_g = raw_pixel & cfg.green_sel;
  assign masked_b = raw_pixel & cfg.blue_sel;
  assign chan[0]  = masked_r[RED_SHIFT +: CHAN_BITS];
  assign chan[1]  = masked_g[GREEN_SHIFT +: CHAN_BITS];
  assign chan[2]  = masked_b[0 +: CHAN_BITS];

  // effective scale and frame size
  always_comb begin
    s_eff = (cfg.scale_log2 > 3'(MAX_SCALE_LOG2)) ? 3'(MAX_SCALE_LOG2) : cfg.scale_log2;
    m     = 4'((5'd1 << s_eff) - 5'd1);
    x     = col[3:0] & m;
    y     = row[3:0] & m;
    fw16  = 16'(cfg.frame_width);
    if (cfg.frame_width == '0) begin
      w_eff = WW'(1);
    end else if (fw16 > 16'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw16);
    end
    if (cfg.frame_height == '0) begin
      h_eff = SIZE_BITS'(1);
    end else if (cfg.frame_height > SIZE_BITS'(MAX_HEIGHT)) begin
      h_eff = SIZE_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.frame_height;
    end
    last_col = (WW'(col) + WW'(1)) >= w_eff;
    last_row = (SIZE_BITS'(row) + SIZE_BITS'(1)) >= h_eff;
  end

  // position and running sums along the current block row
  always_comb begin
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      rbs_next[c] = ((x == 4'd0) ? '0 : rbs[c]) + SUM_BITS'(chan[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      rbs <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      rbs <= rbs_next;
    end
  end

  // a beat goes to the back only when it closes a block row segment
  assign item_push = accept && (x == m);
  assign item_addr = AW'(col >> s_eff);
  assign item_sum  = rbs_next;
  always_comb begin
    item_ctl.y_zero     = (y == 4'd0);
    item_ctl.is_out     = (y == m);
    item_ctl.frame_done = last_col && last_row;
    item_ctl.shift      = s_eff;
  end

endmodule

>>> rtl/rbd_back.sv
// Back end: column sum memory, read-modify-write, averaging and result queue.
`timescale 1ns / 1ps
module rbd_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int SUM_BITS  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_empty,
  output logic                                       q_pop,
  input  logic [$clog2((MAX_WIDTH+1)/2)-1:0]         q_addr,
  input  logic [rbd_pkg::NUM_CHAN-1:0][SUM_BITS-1:0] q_sum,
  input  rbd_pkg::ctl_t                              q_ctl,
  output logic                                       busy,
  input  logic                                       pop,
  output logic                                       empty,
  output logic [7:0]                                 red_avg,
  output logic [7:0]                                 green_avg,
  output logic [7:0]                                 blue_avg,
  output logic                                       frame_done
);
  import rbd_pkg::*;

  localparam int COL_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW        = $clog2(COL_DEPTH);
  localparam int RW        = NUM_CHAN * CHAN_BITS + 1;

  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  col_mem [COL_DEPTH];
  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  rd;
  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  tot;
  logic [NUM_CHAN-1:0][CHAN_BITS-1:0] avg;
  logic [NUM_CHAN-1:0][SUM_BITS-1:0]  b1_sum;
  logic [AW-1:0]                      b1_addr;
  ctl_t                               b1_ctl;
  logic                               b1_valid;
  logic                               b1_fire;
  logic                               we;
  logic                               clearing;
  logic [AW-1:0]                      clr_addr;
  logic                               res_push;
  logic                               res_full;
  logic [RW-1:0]                      res_wdata;
  logic [RW-1:0]                      res_rdata;

  assign busy = clearing;

  // block totals and averages for the beat in the stage
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      tot[c] = (b1_ctl.y_zero ? '0 : rd[c]) + b1_sum[c];
      avg[c] = CHAN_BITS'(tot[c] >> {b1_ctl.shift, 1'b0});
    end
  end

  assign b1_fire  = b1_valid && (!b1_ctl.is_out || !res_full);
  assign q_pop    = !q_empty && (!b1_valid || b1_fire);
  assign we       = b1_fire && !b1_ctl.is_out;
  assign res_push = b1_fire && b1_ctl.is_out;

  // stage control and the clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (q_pop) begin
        b1_valid <= 1'b1;
      end else if (b1_fire) begin
        b1_valid <= 1'b0;
      end
      if (clearing) begin
        if (clr_addr == AW'(COL_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_addr <= q_addr;
      b1_sum  <= q_sum;
      b1_ctl  <= q_ctl;
    end
  end

  // column sum memory write
  always_ff @(posedge clk) begin
    if (clearing) begin
      col_mem[clr_addr] <= '0;
    end else if (we) begin
      col_mem[b1_addr] <= tot;
    end
  end

  // column sum memory read, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd <= (we && (b1_addr == q_addr)) ? tot : col_mem[q_addr];
    end
  end

  // result queue
  assign res_wdata = {avg[0], avg[1], avg[2], b1_ctl.frame_done};

  rbd_queue #(
    .W     (RW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign red_avg    = res_rdata[RW-1 -: CHAN_BITS];
  assign green_avg  = res_rdata[RW-1-CHAN_BITS -: CHAN_BITS];
  assign blue_avg   = res_rdata[RW-1-2*CHAN_BITS -: CHAN_BITS];
  assign frame_done = res_rdata[0];

endmodule
